[rtl/arnr_pkg.sv]
// Shared types and constants for the nearest-neighbour resampling audio ring.
package arnr_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FRAME_BITS     = 2 * SAMPLE_BITS;
    localparam int DEPTH_BITS     = 13;
    localparam int RATE_BITS      = 17;
    localparam int PHASE_BITS     = 18;
    localparam int CFG_INDEX_BITS = 2;
    localparam int USER_BITS      = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_RING_DEPTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INPUT_RATE  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUTPUT_RATE = 2'd2;

    // Operation codes carried in s_tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [DEPTH_BITS-1:0] RESET_RING_DEPTH = 13'd4096;
    localparam logic [RATE_BITS-1:0]  RESET_RATE       = 17'd48000;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } ctrl_state_t;

    typedef struct packed {
        logic                          underrun;
        logic                          ring_full;
        logic                          frame_taken;
        logic signed [SAMPLE_BITS-1:0] out_right;
        logic signed [SAMPLE_BITS-1:0] out_left;
    } result_t;

endpackage

[rtl/arnr_frame_ram.sv]
// Single-port frame store with registered read data.
module arnr_frame_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic                            we,
    input  logic [AW-1:0]                   addr,
    input  logic [arnr_pkg::FRAME_BITS-1:0] wdata,
    output logic [arnr_pkg::FRAME_BITS-1:0] rdata
);
    import arnr_pkg::*;

    logic [FRAME_BITS-1:0] ram_mem [DEPTH];
    logic [FRAME_BITS-1:0] rdata_reg;

    // One access per cycle: write, or read into the output register
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                ram_mem[addr] <= wdata;
            end else begin
                rdata_reg <= ram_mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/arnr_ring_ctrl.sv]
// Ring indices, phase accumulator, configuration registers and sequencer.
module arnr_ring_ctrl #(
    parameter int MAX_FRAMES = 4096,
    parameter int AW         = 12,
    parameter int CW         = 13
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration writes
    input  logic                                cfg_valid,
    input  logic [arnr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [arnr_pkg::RATE_BITS-1:0]      cfg_data,
    // input transactions
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                in_op,
    input  logic [arnr_pkg::SAMPLE_BITS-1:0]    in_left,
    input  logic [arnr_pkg::SAMPLE_BITS-1:0]    in_right,
    // results towards the output stage
    input  logic                                slot_free,
    output logic                                res_valid,
    output arnr_pkg::result_t                   res,
    // frame store port
    output logic                                ram_en,
    output logic                                ram_we,
    output logic [AW-1:0]                       ram_addr,
    output logic [arnr_pkg::FRAME_BITS-1:0]     ram_wdata,
    input  logic [arnr_pkg::FRAME_BITS-1:0]     ram_rdata
);
    import arnr_pkg::*;

    localparam int DW = (CW > DEPTH_BITS) ? CW : DEPTH_BITS;
    localparam int RESET_DEPTH_INT = (MAX_FRAMES < 4096) ? MAX_FRAMES : 4096;
    localparam logic [CW-1:0] RESET_DEPTH = CW'(RESET_DEPTH_INT);
    localparam logic [DW-1:0] MAX_DEPTH   = DW'(MAX_FRAMES);

    ctrl_state_t state_reg, state_next;

    logic [CW-1:0]         depth_reg, depth_next;
    logic [RATE_BITS-1:0]  in_rate_reg, in_rate_next;
    logic [RATE_BITS-1:0]  out_rate_reg, out_rate_next;
    logic [AW-1:0]         wr_idx_reg, wr_idx_next;
    logic [AW-1:0]         rd_idx_reg, rd_idx_next;
    logic [AW-1:0]         guard_reg, guard_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;

    logic                  accept, push_go, pull_go;
    logic                  depth_on, is_full, same_rate, push_ok;
    logic                  ph_write, ph_taken;
    logic [PHASE_BITS-1:0] phase_add, phase_sub;
    logic                  push_write, push_taken, pull_empty, pull_read;
    logic [DW-1:0]         cfg_depth_ext;
    logic [CW-1:0]         cfg_depth_eff;
    logic [CW-1:0]         wr_inc, rd_inc;

    // Decode of the offered transaction
    assign accept   = in_valid && in_ready;
    assign push_go  = accept && (in_op == OP_PUSH);
    assign pull_go  = accept && (in_op == OP_PULL);
    assign depth_on = (depth_reg != '0);
    assign is_full  = (wr_idx_reg == guard_reg);
    assign same_rate = (in_rate_reg == out_rate_reg);
    assign push_ok  = push_go && depth_on && !is_full;

    // Nearest-neighbour phase: write a copy below threshold, take at or above
    assign ph_write  = ({1'b0, out_rate_reg} > phase_reg);
    assign phase_add = ph_write ? (phase_reg + PHASE_BITS'(in_rate_reg)) : phase_reg;
    assign ph_taken  = (phase_add >= {1'b0, out_rate_reg});
    assign phase_sub = ph_taken ? (phase_add - PHASE_BITS'(out_rate_reg)) : phase_add;

    assign push_write = push_ok && (same_rate || ph_write);
    assign push_taken = push_ok && (same_rate || ph_taken);
    assign pull_empty = !depth_on || (rd_idx_reg == wr_idx_reg);
    assign pull_read  = pull_go && !pull_empty;

    // Depth written above the store size saturates
    assign cfg_depth_ext = DW'(cfg_data[DEPTH_BITS-1:0]);
    assign cfg_depth_eff = (cfg_depth_ext > MAX_DEPTH) ? CW'(MAX_DEPTH) : CW'(cfg_depth_ext);

    assign wr_inc = CW'(wr_idx_reg) + CW'(1);
    assign rd_inc = CW'(rd_idx_reg) + CW'(1);

    // Register and index update
    always_comb begin
        depth_next    = depth_reg;
        in_rate_next  = in_rate_reg;
        out_rate_next = out_rate_reg;
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        guard_next    = guard_reg;
        phase_next    = phase_reg;

        if (push_write) begin
            wr_idx_next = (wr_inc >= depth_reg) ? '0 : wr_inc[AW-1:0];
        end
        if (push_ok && !same_rate) begin
            phase_next = phase_sub;
        end
        if (pull_read) begin
            guard_next  = rd_idx_reg;
            rd_idx_next = (rd_inc >= depth_reg) ? '0 : rd_inc[AW-1:0];
        end

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_RING_DEPTH: begin
                    depth_next  = cfg_depth_eff;
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                    guard_next  = (cfg_depth_eff == '0) ? '0 :
                                  AW'(cfg_depth_eff - CW'(1));
                end
                REG_INPUT_RATE:  in_rate_next  = cfg_data;
                REG_OUTPUT_RATE: out_rate_next = cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (pull_read) state_next = ST_READ;
            ST_READ: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        res       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready        = slot_free;
                res_valid       = accept && !pull_read;
                res.frame_taken = push_taken;
                res.ring_full   = push_go && depth_on && is_full;
                res.underrun    = pull_go && pull_empty;
            end
            ST_READ: begin
                res_valid     = 1'b1;
                res.out_left  = ram_rdata[SAMPLE_BITS-1:0];
                res.out_right = ram_rdata[FRAME_BITS-1:SAMPLE_BITS];
            end
            default: ;
        endcase
    end

    // Frame store access
    assign ram_en    = push_write || pull_read;
    assign ram_we    = push_write;
    assign ram_addr  = push_write ? wr_idx_reg : rd_idx_reg;
    assign ram_wdata = {in_right, in_left};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            depth_reg    <= RESET_DEPTH;
            in_rate_reg  <= RESET_RATE;
            out_rate_reg <= RESET_RATE;
            wr_idx_reg   <= '0;
            rd_idx_reg   <= '0;
            guard_reg    <= AW'(RESET_DEPTH - CW'(1));
            phase_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            depth_reg    <= depth_next;
            in_rate_reg  <= in_rate_next;
            out_rate_reg <= out_rate_next;
            wr_idx_reg   <= wr_idx_next;
            rd_idx_reg   <= rd_idx_next;
            guard_reg    <= guard_next;
            phase_reg    <= phase_next;
        end
    end

endmodule

[rtl/arnr_out_skid.sv]
// Output register with a skid slot, so a waiting result does not block input.
module arnr_out_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              res_valid,
    input  arnr_pkg::result_t res,
    output logic              slot_free,
    output logic              out_valid,
    input  logic              out_ready,
    output arnr_pkg::result_t out_data
);
    import arnr_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    main_open;

    // Main register can load when empty or when its transaction completes
    assign main_open = !main_valid_reg || out_ready;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_open) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = res_valid;
                skid_next       = res;
            end else begin
                main_valid_next = res_valid;
                main_next       = res;
            end
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign slot_free = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

[rtl/audio_ring_nearest_resampler_core.sv]
// Top level: stereo ring buffer with nearest-neighbour resampling on the write side.
// A push or an empty pull has its result registered in the output stage; a pull that
// reads the ring passes the registered ring read and the read state before that stage.
// Throughput: one push per cycle while the skid slot is free; a ring read holds the port.
// Reset (aresetn low, synchronous): depth min(MAX_FRAMES, 4096), both rates 48000, indices
// and phase cleared; ring contents are not swept: only slots written since are read.
module audio_ring_nearest_resampler_core #(
    parameter int MAX_FRAMES = 4096
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [arnr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [arnr_pkg::RATE_BITS-1:0]      cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [arnr_pkg::FRAME_BITS-1:0]     s_tdata,  // push_left, push_right
    input  logic                                s_tuser,  // operation
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [arnr_pkg::FRAME_BITS-1:0]     m_tdata,  // out_left, out_right
    output logic [arnr_pkg::USER_BITS-1:0]      m_tuser   // frame_taken, ring_full, underrun
);
    import arnr_pkg::*;

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);

    logic                  slot_free, res_valid;
    result_t               res, out_data;
    logic                  ram_en, ram_we;
    logic [AW-1:0]         ram_addr;
    logic [FRAME_BITS-1:0] ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;

    arnr_ring_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_left   (s_tdata[SAMPLE_BITS-1:0]),
        .in_right  (s_tdata[FRAME_BITS-1:SAMPLE_BITS]),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_en    (ram_en),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    arnr_frame_ram #(
        .DEPTH (MAX_FRAMES),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    arnr_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.out_right, out_data.out_left};
    assign m_tuser = {out_data.underrun, out_data.ring_full, out_data.frame_taken};

endmodule
